### design/dsfp_pkg.sv
// shared constants for the decimal string to fixed-point converter
// no dependencies
package dsfp_pkg;

    localparam int DECIMALS = 8;
    localparam int VALUE_W = 64;
    localparam int FRAC_W = $clog2(DECIMALS + 2);

    localparam logic [1:0] PHASE_SPACE = 2'd0;
    localparam logic [1:0] PHASE_SIGN = 2'd1;
    localparam logic [1:0] PHASE_DIGITS = 2'd2;
    localparam logic [1:0] PHASE_STOP = 2'd3;

    localparam logic [7:0] CHAR_DOT = 8'h2E;
    localparam logic [7:0] CHAR_ZERO = 8'h30;
    localparam logic [7:0] CHAR_NINE = 8'h39;
    localparam logic [7:0] CHAR_PLUS = 8'h2B;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_TAB = 8'h09;
    localparam logic [7:0] CHAR_CR = 8'h0D;

    typedef struct packed {
        logic [VALUE_W-1:0] acc;
        logic sat;
    } acc_state_t;

endpackage

### design/dsfp_mac10.sv
// shared multiply-by-ten-and-add unit with saturation on overflow
// depends on dsfp_pkg
module dsfp_mac10 (
    input  dsfp_pkg::acc_state_t state_in,
    input  logic [3:0]           digit,
    output dsfp_pkg::acc_state_t state_out
);
    import dsfp_pkg::*;

    logic [VALUE_W+3:0] wide;
    logic [VALUE_W+3:0] prod;
    logic               ovf;

    always_comb
    begin
        wide = {4'b0000, state_in.acc};
        prod = (wide << 3) + (wide << 1) + {{VALUE_W{1'b0}}, digit};
        ovf = |prod[VALUE_W+3:VALUE_W];
        if (state_in.sat)
        begin
            state_out = state_in;
        end
        else if (ovf)
        begin
            state_out.acc = {VALUE_W{1'b1}};
            state_out.sat = 1'b1;
        end
        else
        begin
            state_out.acc = prod[VALUE_W-1:0];
            state_out.sat = 1'b0;
        end
    end

endmodule

### design/decimal_string_to_fixed_point_top.sv
// non-final characters are accepted one per cycle; after the final character the pad
// state shifts in one padding zero per cycle through the shared x10 unit, then the
// finish state loads the output register; pad = DECIMALS minus fraction characters
// (zero once the parse has stopped); in_ready is low until the result is loaded,
// which also waits while an earlier word is stalled on the output
// rst_n is asynchronous active low and clears all control and scan state
module decimal_string_to_fixed_point_top (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [7:0]                    text_byte,
    input  logic                          last_byte,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [dsfp_pkg::VALUE_W-1:0]  scaled_value,
    output logic                          well_formed,
    output logic                          overflowed
);
    import dsfp_pkg::*;

    localparam logic [1:0] ST_SCAN = 2'd0;
    localparam logic [1:0] ST_PAD = 2'd1;
    localparam logic [1:0] ST_FIN = 2'd2;

    localparam logic [FRAC_W-1:0] DEC_F = FRAC_W'(DECIMALS);
    localparam logic [FRAC_W-1:0] ONE_F = FRAC_W'(1);

    logic [1:0]        state_reg, state_next;
    acc_state_t        acc_reg, acc_next;
    logic [1:0]        phase_reg, phase_next;
    logic              point_reg, point_next;
    logic [FRAC_W-1:0] frac_reg, frac_next;
    logic              minus_reg, minus_next;
    logic [FRAC_W-1:0] pad_reg, pad_next;

    logic                out_valid_reg, out_valid_next;
    logic [VALUE_W-1:0]  value_reg;
    logic                good_reg;
    logic                ovf_reg;

    acc_state_t unit_out;
    logic [3:0] unit_digit;
    logic       is_digit;
    logic       is_space;
    logic       accept;
    logic       load_out;
    logic [FRAC_W-1:0] pad_calc;

    dsfp_mac10 u_mac10 (
        .state_in  (acc_reg),
        .digit     (unit_digit),
        .state_out (unit_out)
    );

    assign in_ready = (state_reg == ST_SCAN);
    assign accept = in_valid && in_ready;
    assign load_out = (state_reg == ST_FIN) && (!out_valid_reg || out_ready);

    always_comb
    begin
        is_digit = (text_byte >= CHAR_ZERO) && (text_byte <= CHAR_NINE);
        is_space = (text_byte == CHAR_SPACE)
                   || ((text_byte >= CHAR_TAB) && (text_byte <= CHAR_CR));
        unit_digit = (state_reg == ST_SCAN) ? text_byte[3:0] : 4'd0;

        state_next = state_reg;
        acc_next = acc_reg;
        phase_next = phase_reg;
        point_next = point_reg;
        frac_next = frac_reg;
        minus_next = minus_reg;
        pad_next = pad_reg;
        pad_calc = '0;

        case (state_reg)
            ST_SCAN:
            begin
                if (accept)
                begin
                    if (!point_reg && (text_byte == CHAR_DOT))
                    begin
                        point_next = 1'b1;
                    end
                    else
                    begin
                        if (point_reg && (frac_reg <= DEC_F))
                        begin
                            frac_next = frac_reg + ONE_F;
                        end
                        if (phase_reg != PHASE_STOP)
                        begin
                            if (is_digit)
                            begin
                                phase_next = PHASE_DIGITS;
                                acc_next = unit_out;
                            end
                            else if ((phase_reg == PHASE_SPACE) && is_space)
                            begin
                                phase_next = phase_reg;
                            end
                            else if ((phase_reg == PHASE_SPACE)
                                     && ((text_byte == CHAR_PLUS)
                                         || (text_byte == CHAR_MINUS)))
                            begin
                                minus_next = (text_byte == CHAR_MINUS);
                                phase_next = PHASE_SIGN;
                            end
                            else
                            begin
                                phase_next = PHASE_STOP;
                            end
                        end
                    end
                    if (last_byte)
                    begin
                        if (!point_next)
                        begin
                            pad_calc = DEC_F;
                        end
                        else if (frac_next < DEC_F)
                        begin
                            pad_calc = DEC_F - frac_next;
                        end
                        pad_next = pad_calc;
                        if ((phase_next == PHASE_STOP) || (pad_calc == '0))
                        begin
                            state_next = ST_FIN;
                        end
                        else
                        begin
                            state_next = ST_PAD;
                        end
                    end
                end
            end
            ST_PAD:
            begin
                acc_next = unit_out;
                pad_next = pad_reg - ONE_F;
                if (pad_reg == ONE_F)
                begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                if (load_out)
                begin
                    state_next = ST_SCAN;
                    acc_next = '0;
                    phase_next = PHASE_SPACE;
                    point_next = 1'b0;
                    frac_next = '0;
                    minus_next = 1'b0;
                end
            end
            default:
            begin
                state_next = ST_SCAN;
            end
        endcase

        out_valid_next = out_valid_reg;
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_SCAN;
            acc_reg <= '0;
            phase_reg <= PHASE_SPACE;
            point_reg <= 1'b0;
            frac_reg <= '0;
            minus_reg <= 1'b0;
            pad_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            acc_reg <= acc_next;
            phase_reg <= phase_next;
            point_reg <= point_next;
            frac_reg <= frac_next;
            minus_reg <= minus_next;
            pad_reg <= pad_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            if (acc_reg.sat)
            begin
                value_reg <= {VALUE_W{1'b1}};
            end
            else if (minus_reg)
            begin
                value_reg <= {VALUE_W{1'b0}} - acc_reg.acc;
            end
            else
            begin
                value_reg <= acc_reg.acc;
            end
            good_reg <= !point_reg || (frac_reg <= DEC_F);
            ovf_reg <= acc_reg.sat;
        end
    end

    assign out_valid = out_valid_reg;
    assign scaled_value = value_reg;
    assign well_formed = good_reg;
    assign overflowed = ovf_reg;

endmodule

### design/dsfp_checker.sv
// port-level checks for the decimal string converter, bound to the top level
// depends on dsfp_pkg and decimal_string_to_fixed_point_top
module dsfp_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_valid,
    input logic                          in_ready,
    input logic [7:0]                    text_byte,
    input logic                          last_byte,
    input logic                          out_valid,
    input logic                          out_ready,
    input logic [dsfp_pkg::VALUE_W-1:0]  scaled_value,
    input logic                          well_formed,
    input logic                          overflowed
);
    import dsfp_pkg::*;

    // saturated result is all ones
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && overflowed |-> (scaled_value == {VALUE_W{1'b1}}))
        else $error("overflowed word is not all ones");

    // a final character blocks input for at least the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && last_byte |=> !in_ready)
        else $error("input taken right after final character");

    // a non-final character never produces a word
    assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid && in_valid && in_ready && !last_byte |=> !out_valid)
        else $error("word produced without final character");

    // stalled output word holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(scaled_value)
            && $stable(well_formed) && $stable(overflowed))
        else $error("stalled output word changed");

endmodule

bind decimal_string_to_fixed_point_top dsfp_checker u_dsfp_checker (.*);

### sim/dsfp_price_checker.sv
`timescale 1ns / 1ps
// checker for the decimal string to fixed-point converter: watches both channels,
// predicts each price word from the accepted characters and compares the results
// depends on dsfp_pkg
module dsfp_price_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic                          in_ready,
    input  logic [7:0]                    text_byte,
    input  logic                          last_byte,
    input  logic                          out_valid,
    input  logic                          out_ready,
    input  logic [dsfp_pkg::VALUE_W-1:0]  scaled_value,
    input  logic                          well_formed,
    input  logic                          overflowed,
    output int                            mismatches,
    output int                            pending,
    output int                            words_checked
);
    import dsfp_pkg::*;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic               wf;
        logic               ovf;
    } price_word_t;

    localparam logic [VALUE_W-1:0] ALL_ONES = '1;

    price_word_t        price_q[$];
    logic [VALUE_W-1:0] acc;
    logic [1:0]         phase;
    logic               point_seen;
    logic [5:0]         frac_cnt;
    logic               minus;
    logic               sat;
    int                 err_cnt = 0;
    int                 queued = 0;
    int                 checked = 0;

    assign mismatches    = err_cnt;
    assign pending       = queued;
    assign words_checked = checked;

    task automatic clear_scan();
        acc        = '0;
        phase      = PHASE_SPACE;
        point_seen = 1'b0;
        frac_cnt   = '0;
        minus      = 1'b0;
        sat        = 1'b0;
    endtask

    task automatic shift_in_digit(input logic [3:0] d);
        if (!sat)
        begin
            if (acc > (ALL_ONES - VALUE_W'(d)) / 10)
            begin
                sat = 1'b1;
                acc = ALL_ONES;
            end
            else
            begin
                acc = acc * 10 + VALUE_W'(d);
            end
        end
    endtask

    task automatic scan_char(input logic [7:0] c);
        logic [7:0] offs;
        offs = c - CHAR_ZERO;
        if (phase != PHASE_STOP)
        begin
            if (c >= CHAR_ZERO && c <= CHAR_NINE)
            begin
                phase = PHASE_DIGITS;
                shift_in_digit(offs[3:0]);
            end
            else if (phase == PHASE_SPACE &&
                     (c == CHAR_SPACE || (c >= CHAR_TAB && c <= CHAR_CR)))
            begin
                // whitespace skipped before the number only
            end
            else if (phase == PHASE_SPACE && (c == CHAR_PLUS || c == CHAR_MINUS))
            begin
                minus = (c == CHAR_MINUS);
                phase = PHASE_SIGN;
            end
            else
            begin
                phase = PHASE_STOP;
            end
        end
    endtask

    task automatic take_word(input logic [7:0] c, input logic fin);
        int          pad;
        price_word_t w;
        if (!point_seen && c == CHAR_DOT)
        begin
            point_seen = 1'b1;
        end
        else
        begin
            if (point_seen && frac_cnt <= DECIMALS)
                frac_cnt++;
            scan_char(c);
        end
        if (fin)
        begin
            if (!point_seen)
                pad = DECIMALS;
            else if (frac_cnt < DECIMALS)
                pad = DECIMALS - int'(frac_cnt);
            else
                pad = 0;
            w.wf = !(point_seen && frac_cnt > DECIMALS);
            // padding only scales a parse that ran to the end
            if (phase != PHASE_STOP)
                repeat (pad) shift_in_digit(4'd0);
            if (sat)
                w.value = ALL_ONES;
            else if (minus)
                w.value = -acc;
            else
                w.value = acc;
            w.ovf = sat;
            price_q.insert(price_q.size(), w);
            clear_scan();
        end
    endtask

    task automatic check_word();
        price_word_t w;
        if (price_q.size() == 0)
        begin
            $error("unexpected word: scaled_value %h well_formed %b overflowed %b",
                   scaled_value, well_formed, overflowed);
            err_cnt++;
        end
        else
        begin
            w = price_q.pop_front();
            checked++;
            if (scaled_value !== w.value)
            begin
                $error("scaled_value: expected %h, actual %h", w.value, scaled_value);
                err_cnt++;
            end
            if (well_formed !== w.wf)
            begin
                $error("well_formed: expected %b, actual %b", w.wf, well_formed);
                err_cnt++;
            end
            if (overflowed !== w.ovf)
            begin
                $error("overflowed: expected %b, actual %b", w.ovf, overflowed);
                err_cnt++;
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_scan();
            price_q.delete();
        end
        else
        begin
            if (out_valid && out_ready)
                check_word();
            if (in_valid && in_ready)
                take_word(text_byte, last_byte);
        end
        queued = price_q.size();
    end

endmodule

### sim/tb_decimal_string_to_fixed_point_top.sv
`timescale 1ns / 1ps
// testbench top for decimal_string_to_fixed_point_top: drives price strings with
// random gaps and stalls; checking is done by dsfp_price_checker, depends on dsfp_pkg
module tb_decimal_string_to_fixed_point_top;
    import dsfp_pkg::*;

    localparam int LIMIT        = 400000;
    localparam int RANDOM_CHARS = 1450;
    localparam int HOLD_AT_WORD = 40;
    localparam int HOLD_CYCLES  = 600;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                in_valid = 1'b0;
    logic                in_ready;
    logic [7:0]          text_byte = 8'h00;
    logic                last_byte = 1'b0;
    logic                out_valid;
    logic                out_ready = 1'b0;
    logic [VALUE_W-1:0]  scaled_value;
    logic                well_formed;
    logic                overflowed;

    int         mismatches;
    int         pending;
    int         words_checked;
    int         cycle_count = 0;
    int         chars_sent = 0;
    int         rx_words = 0;
    int         rx_wait = 0;
    logic       rx_hold = 1'b0;
    logic       tx_burst = 1'b0;
    logic       rx_burst = 1'b0;
    logic [7:0] str_q[$];

    decimal_string_to_fixed_point_top i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .text_byte    (text_byte),
        .last_byte    (last_byte),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .scaled_value (scaled_value),
        .well_formed  (well_formed),
        .overflowed   (overflowed)
    );

    dsfp_price_checker i_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .text_byte     (text_byte),
        .last_byte     (last_byte),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .scaled_value  (scaled_value),
        .well_formed   (well_formed),
        .overflowed    (overflowed),
        .mismatches    (mismatches),
        .pending       (pending),
        .words_checked (words_checked)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    always @(posedge clk)
        cycle_count <= cycle_count + 1;

    initial
    begin
        wait (cycle_count >= LIMIT);
        $display("timeout after %0d cycles, %0d words still expected", cycle_count, pending);
        $display("** decimal_string_to_fixed_point_top: FAILED **");
        $finish;
    end

    // receiver side
    initial
    begin
        forever
        begin
            @(negedge clk);
            out_ready = (rx_wait == 0) && !rx_hold;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            rx_words++;
            if ($urandom_range(7, 0) == 0)
                rx_burst = !rx_burst;
            if (rx_burst)
                rx_wait = 0;
            else
                rx_wait = $urandom_range(17, 0);
        end
        else if (rx_wait > 0)
        begin
            rx_wait--;
        end
    end

    // long receiver hold so the block fills up and stalls its input
    initial
    begin
        wait (rx_words == HOLD_AT_WORD);
        @(posedge clk);
        rx_hold = 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        rx_hold = 1'b0;
    end

    function automatic logic [7:0] rand_digit();
        logic [7:0] d;
        d = 8'($urandom_range(9, 0));
        return CHAR_ZERO + d;
    endfunction

    function automatic logic [7:0] rand_byte();
        logic [7:0] b;
        b = 8'($urandom_range(255, 0));
        return b;
    endfunction

    task automatic put_char(input logic [7:0] c);
        str_q.insert(str_q.size(), c);
    endtask

    task automatic send_char(input logic [7:0] c, input logic fin);
        int gap;
        gap = tx_burst ? 0 : $urandom_range(17, 0);
        if (gap > 0)
        begin
            in_valid  = 1'b0;
            text_byte = rand_byte();
            last_byte = 1'($urandom_range(1, 0));
            repeat (gap) @(negedge clk);
        end
        in_valid  = 1'b1;
        text_byte = c;
        last_byte = fin;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        chars_sent++;
        @(negedge clk);
        if ($urandom_range(15, 0) == 0)
            tx_burst = !tx_burst;
    endtask

    task automatic send_string();
        for (int i = 0; i < str_q.size(); i++)
            send_char(str_q[i], i == str_q.size() - 1);
        str_q.delete();
    endtask

    task automatic add_text(input string s);
        for (int i = 0; i < s.len(); i++)
            put_char(s[i]);
    endtask

    task automatic build_price();
        int         kind;
        int         n;
        int         ws;
        logic [7:0] c;
        kind = $urandom_range(9, 0);
        if (kind < 2)
        begin
            n = $urandom_range(8, 1);
            repeat (n) put_char(rand_byte());
        end
        else
        begin
            if ($urandom_range(3, 0) == 0)
            begin
                repeat ($urandom_range(2, 1))
                begin
                    ws = $urandom_range(5, 0);
                    c = (ws == 5) ? CHAR_SPACE : CHAR_TAB + 8'(ws);
                    put_char(c);
                end
            end
            case ($urandom_range(3, 0))
                0: put_char(CHAR_PLUS);
                1: put_char(CHAR_MINUS);
                default: ;
            endcase
            n = ($urandom_range(9, 0) == 0) ? $urandom_range(20, 10) : $urandom_range(6, 0);
            repeat (n) put_char(rand_digit());
            if ($urandom_range(3, 0) != 0)
            begin
                put_char(CHAR_DOT);
                n = ($urandom_range(4, 0) == 0) ? $urandom_range(12, 9) : $urandom_range(8, 0);
                repeat (n) put_char(rand_digit());
            end
            if ($urandom_range(7, 0) == 0)
                put_char(rand_byte());
            if (str_q.size() == 0)
                put_char(rand_digit());
            // broken string: one character replaced by noise
            if (kind == 2)
                str_q[$urandom_range(str_q.size() - 1, 0)] = rand_byte();
        end
    endtask

    initial
    begin
        int start;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        add_text("\t+1.x");
        send_string();
        add_text("-3");
        send_string();
        put_char(8'hFF);
        put_char(8'h00);
        send_string();
        add_text(".1.2345678");
        send_string();
        add_text("999999999999");
        send_string();
        add_text("-.");
        send_string();

        start = chars_sent;
        while (chars_sent - start < RANDOM_CHARS)
        begin
            build_price();
            send_string();
        end
        in_valid = 1'b0;

        while (pending != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        $display("checked %0d price words built from %0d characters", words_checked, chars_sent);
        $display("mix: whitespace, signs, short and long fractions, overflow, noise, long stall");
        if (mismatches == 0)
            $display("** decimal_string_to_fixed_point_top: PASSED **");
        else
            $display("** decimal_string_to_fixed_point_top: FAILED **");
        $finish;
    end

endmodule

### decimal_string_to_fixed_point_top.f
design/dsfp_pkg.sv
design/dsfp_mac10.sv
design/decimal_string_to_fixed_point_top.sv
design/dsfp_checker.sv
sim/dsfp_price_checker.sv
sim/tb_decimal_string_to_fixed_point_top.sv
